FILE: sv/ptit_pkg.sv
// Shared types, codes and saturation helpers for the point-in-triangle test.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps

package ptit_pkg;

    localparam int TRI_COUNT_DEF = 256;
    localparam int FRAC_BITS_DEF = 16;

    // input opcodes
    localparam logic [2:0] OP_LOAD_A = 3'd0;
    localparam logic [2:0] OP_LOAD_B = 3'd1;
    localparam logic [2:0] OP_LOAD_C = 3'd2;
    localparam logic [2:0] OP_LOAD_N = 3'd3;
    localparam logic [2:0] OP_QUERY  = 3'd4;

    // job kinds after classification
    localparam logic [1:0] KIND_LOAD  = 2'd0;
    localparam logic [1:0] KIND_QUERY = 2'd1;
    localparam logic [1:0] KIND_OOB   = 2'd2;

    localparam int QDEPTH = 4;
    localparam int QPTR_W = 2;

    typedef struct packed {
        logic [1:0]         kind;
        logic [1:0]         slot;
        logic [7:0]         idx;
        logic signed [31:0] x;
        logic signed [31:0] y;
        logic signed [31:0] z;
    } job_t;

    function automatic logic signed [31:0] sat32(input logic signed [67:0] x);
        if (x > 68'sd2147483647)
            return 32'sh7FFFFFFF;
        else if (x < -68'sd2147483648)
            return 32'sh80000000;
        return x[31:0];
    endfunction

    function automatic logic signed [47:0] sat48(input logic signed [67:0] x);
        if (x > 68'sd140737488355327)
            return 48'sh7FFFFFFFFFFF;
        else if (x < -68'sd140737488355328)
            return 48'sh800000000000;
        return x[47:0];
    endfunction

endpackage

FILE: sv/point_in_triangle_test.sv
// Barycentric point-in-triangle test over a table of triangles.
// Input beats (s_axis): tuser carries the opcode: load corner A, B, C, the
// plane normal, or a query. Loads write one coordinate triple of one table
// entry and give no output beat; a query gives one output beat (m_axis) with
// u, v in signed Q16.16 and the inside and degenerate flags.
// Unused opcodes and loads to entries past the table are dropped.
// Work: a load is written to the table when the back end pops it; a query
// runs on the single shared 33x33 multiplier (3 distance, 3 projection and
// 15 dot-product steps and 24 partial products for the wide terms) and the
// 35-step divider that forms u and v side by side. The front accepts beats
// into a 4-deep job queue while the back works, so up to four jobs can wait.
// Reset clears control state only; the triangle memory holds garbage until
// loaded. A stalled receiver holds the result in the output register; the
// back end then waits before loading its next result and the queue fills.
// Depends on ptit_pkg, ptit_front, ptit_queue, ptit_back.
`timescale 1ns / 1ps

module point_in_triangle_test
    import ptit_pkg::*;
#(
    parameter int TRI_COUNT = TRI_COUNT_DEF,
    parameter int FRAC_BITS = FRAC_BITS_DEF
)
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    input  logic [103:0] s_axis_tdata,  // tri_index, coord_x, coord_y, coord_z
    input  logic [2:0]   s_axis_tuser,  // opcode
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    output logic [63:0]  m_axis_tdata,  // bary_u, bary_v
    output logic [1:0]   m_axis_tuser   // inside_res, degenerate
);

    logic q_full;
    logic q_push;
    job_t q_in_job;
    logic q_pop;
    logic q_valid;
    job_t q_head_job;

    // classify beats and push jobs
    ptit_front #(
        .TRI_COUNT (TRI_COUNT)
    ) u_front (
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .q_full        (q_full),
        .q_push        (q_push),
        .q_job         (q_in_job)
    );

    // decouple front and back
    ptit_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (q_push),
        .push_job   (q_in_job),
        .full       (q_full),
        .pop        (q_pop),
        .head_valid (q_valid),
        .head_job   (q_head_job)
    );

    // memory, arithmetic and output register
    ptit_back #(
        .TRI_COUNT (TRI_COUNT),
        .FRAC_BITS (FRAC_BITS)
    ) u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .q_valid       (q_valid),
        .q_job         (q_head_job),
        .q_pop         (q_pop),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

endmodule

FILE: sv/ptit_front.sv
// Input side: decodes the opcode, drops unused codes and out-of-range loads,
// and pushes jobs into the queue. Depends on ptit_pkg.
`timescale 1ns / 1ps

module ptit_front
    import ptit_pkg::*;
#(
    parameter int TRI_COUNT = TRI_COUNT_DEF
)
(
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    input  logic [103:0] s_axis_tdata,
    input  logic [2:0]   s_axis_tuser,
    input  logic         q_full,
    output logic         q_push,
    output job_t         q_job
);

    logic keep;
    logic oob;

    assign s_axis_tready = !q_full;
    assign oob = 17'(s_axis_tdata[7:0]) >= 17'(TRI_COUNT);

    always_comb
    begin
        q_job.idx  = s_axis_tdata[7:0];
        q_job.x    = s_axis_tdata[39:8];
        q_job.y    = s_axis_tdata[71:40];
        q_job.z    = s_axis_tdata[103:72];
        q_job.slot = s_axis_tuser[1:0];
        q_job.kind = KIND_LOAD;
        keep       = 1'b0;
        unique case (s_axis_tuser) inside
            OP_LOAD_A, OP_LOAD_B, OP_LOAD_C, OP_LOAD_N:
            begin
                keep = !oob;
            end
            OP_QUERY:
            begin
                keep       = 1'b1;
                q_job.kind = oob ? KIND_OOB : KIND_QUERY;
            end
            default:
            begin
                keep = 1'b0;
            end
        endcase
    end

    assign q_push = s_axis_tvalid && s_axis_tready && keep;

endmodule

FILE: sv/ptit_queue.sv
// Short job queue between front and back so each side stalls on its own.
// Depends on ptit_pkg.
`timescale 1ns / 1ps

module ptit_queue
    import ptit_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic push,
    input  job_t push_job,
    output logic full,
    input  logic pop,
    output logic head_valid,
    output job_t head_job
);

    job_t              slot_reg [QDEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg;
    logic [QPTR_W-1:0] rd_ptr_reg;
    logic [QPTR_W:0]   count_reg;

    assign full       = count_reg == (QPTR_W+1)'(QDEPTH);
    assign head_valid = count_reg != '0;
    assign head_job   = slot_reg[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (push)
            slot_reg[wr_ptr_reg] <= push_job;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            if (pop)
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            count_reg <= count_reg + (QPTR_W+1)'(push) - (QPTR_W+1)'(pop);
        end
    end

endmodule

FILE: sv/ptit_back.sv
// Back end: triangle memory, shared multiplier sequencer, two-lane restoring
// divider and the output register. Depends on ptit_pkg.
`timescale 1ns / 1ps

module ptit_back
    import ptit_pkg::*;
#(
    parameter int TRI_COUNT = TRI_COUNT_DEF,
    parameter int FRAC_BITS = FRAC_BITS_DEF
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        q_valid,
    input  job_t        q_job,
    output logic        q_pop,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [63:0] m_axis_tdata,
    output logic [1:0]  m_axis_tuser
);

    localparam int IW    = (TRI_COUNT > 1) ? $clog2(TRI_COUNT) : 1;
    localparam int AW    = IW + 2;
    localparam int DIVW  = 131;
    localparam int DLAST = 34;

    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] S_READ = 4'd1;
    localparam logic [3:0] S_PREP = 4'd2;
    localparam logic [3:0] S_DIST = 4'd3;
    localparam logic [3:0] S_PROJ = 4'd4;
    localparam logic [3:0] S_DOT  = 4'd5;
    localparam logic [3:0] S_WIDE = 4'd6;
    localparam logic [3:0] S_DIV  = 4'd7;
    localparam logic [3:0] S_DONE = 4'd8;

    logic [3:0] state_reg, state_next;
    logic [5:0] step_reg, step_next;
    logic [2:0] hi_reg, hi_next;
    logic [1:0] lo_reg, lo_next;
    logic       pv_reg;
    logic       out_valid_reg, out_valid_next;
    logic       out_load;

    logic [95:0]    mem [4*TRI_COUNT];
    logic [95:0]    rdata_reg;
    logic [AW-1:0]  rd_addr;
    logic [AW-1:0]  wr_addr;

    logic [7:0]         idx_reg;
    logic signed [31:0] p_reg  [3];
    logic signed [31:0] a_reg  [3];
    logic signed [31:0] b_reg  [3];
    logic signed [31:0] c_reg  [3];
    logic signed [31:0] n_reg  [3];
    logic signed [31:0] pa_reg [3];
    logic signed [31:0] ab_reg [3];
    logic signed [31:0] ac_reg [3];
    logic signed [31:0] w_reg  [3];
    logic signed [31:0] dist_reg;
    logic signed [47:0] d_reg  [5];
    logic signed [67:0] acc_reg;
    logic signed [97:0] den_reg, nu_reg, nv_reg;
    logic               degen_reg;

    logic signed [32:0] ma, mb;
    logic signed [65:0] prod_reg;
    logic [2:0]         tag_hi_reg;
    logic [1:0]         tag_lo_reg;
    logic               tag_sign_reg;
    logic               wsign;

    logic [DIVW-1:0] rem_u_reg, rem_v_reg, dsh_reg;
    logic [33:0]     q_u_reg, q_v_reg;
    logic            sat_u_reg, sat_v_reg, neg_u_reg, neg_v_reg;

    logic               out_in_reg, out_dg_reg;
    logic signed [31:0] out_u_reg, out_v_reg;

    logic               in_phase, issue, phase_done;
    logic [2:0]         hi_lim;
    logic [1:0]         lo_last;
    logic signed [65:0] term;
    logic signed [67:0] sum;
    logic signed [31:0] q_proj;
    logic [95:0]        wterm;
    logic signed [97:0] wadd;
    logic signed [47:0] xd, yd;
    logic [47:0]        mx, my;
    logic [16:0]        idx_ext, jidx_ext;

    logic [33:0]        lim_u, lim_v, qf_u, qf_v, nq_u, nq_v;
    logic signed [31:0] u_fin, v_fin;
    logic signed [32:0] uv_sum;
    logic signed [32:0] one_q;
    logic               inside_fin;
    logic [96:0]        abs_nu, abs_nv, abs_den;

    assign idx_ext  = 17'(idx_reg);
    assign jidx_ext = 17'(q_job.idx);
    assign rd_addr  = {idx_ext[IW-1:0], step_reg[1:0]};
    assign wr_addr  = {jidx_ext[IW-1:0], q_job.slot};

    // triangle memory: one row per corner or normal, {z, y, x}
    always_ff @(posedge clk)
    begin
        if (q_pop && q_job.kind == KIND_LOAD)
            mem[wr_addr] <= {q_job.z, q_job.y, q_job.x};
        rdata_reg <= mem[rd_addr];
    end

    // phase limits of the multiplier sequencer
    assign in_phase = state_reg == S_DIST || state_reg == S_PROJ ||
                      state_reg == S_DOT || state_reg == S_WIDE;
    always_comb
    begin
        hi_lim  = 3'd1;
        lo_last = 2'd2;
        case (state_reg)
            S_DOT:   hi_lim = 3'd5;
            S_WIDE:
            begin
                hi_lim  = 3'd6;
                lo_last = 2'd3;
            end
            default: hi_lim = 3'd1;
        endcase
    end
    assign issue      = in_phase && hi_reg < hi_lim;
    assign phase_done = in_phase && !issue && !pv_reg;

    // multiplier operand select
    always_comb
    begin
        ma    = '0;
        mb    = '0;
        wsign = 1'b0;
        xd    = d_reg[0];
        yd    = d_reg[0];
        case (hi_reg)
            3'd0:
            begin
                xd = d_reg[2];
                yd = d_reg[0];
            end
            3'd1:
            begin
                xd = d_reg[1];
                yd = d_reg[1];
            end
            3'd2:
            begin
                xd = d_reg[0];
                yd = d_reg[4];
            end
            3'd3:
            begin
                xd = d_reg[1];
                yd = d_reg[3];
            end
            3'd4:
            begin
                xd = d_reg[2];
                yd = d_reg[3];
            end
            default:
            begin
                xd = d_reg[1];
                yd = d_reg[4];
            end
        endcase
        mx = xd[47] ? 48'(-xd) : xd;
        my = yd[47] ? 48'(-yd) : yd;
        case (state_reg)
            S_DIST:
            begin
                ma = 33'(pa_reg[lo_reg]);
                mb = 33'(n_reg[lo_reg]);
            end
            S_PROJ:
            begin
                ma = 33'(n_reg[lo_reg]);
                mb = 33'(dist_reg);
            end
            S_DOT:
            begin
                case (hi_reg)
                    3'd0:
                    begin
                        ma = 33'(ab_reg[lo_reg]);
                        mb = 33'(ab_reg[lo_reg]);
                    end
                    3'd1:
                    begin
                        ma = 33'(ab_reg[lo_reg]);
                        mb = 33'(ac_reg[lo_reg]);
                    end
                    3'd2:
                    begin
                        ma = 33'(ac_reg[lo_reg]);
                        mb = 33'(ac_reg[lo_reg]);
                    end
                    3'd3:
                    begin
                        ma = 33'(w_reg[lo_reg]);
                        mb = 33'(ab_reg[lo_reg]);
                    end
                    default:
                    begin
                        ma = 33'(w_reg[lo_reg]);
                        mb = 33'(ac_reg[lo_reg]);
                    end
                endcase
            end
            S_WIDE:
            begin
                ma    = $signed({9'b0, lo_reg[1] ? mx[47:24] : mx[23:0]});
                mb    = $signed({9'b0, lo_reg[0] ? my[47:24] : my[23:0]});
                wsign = xd[47] ^ yd[47] ^ hi_reg[0];
            end
            default:
            begin
                ma = '0;
                mb = '0;
            end
        endcase
    end

    // consume side of the multiplier
    assign term   = prod_reg >>> FRAC_BITS;
    assign sum    = acc_reg + 68'(term);
    assign q_proj = sat32(68'(p_reg[tag_lo_reg]) - 68'(term));
    always_comb
    begin
        case (tag_lo_reg)
            2'd0:    wterm = {48'b0, prod_reg[47:0]};
            2'd3:    wterm = {prod_reg[47:0], 48'b0};
            default: wterm = {24'b0, prod_reg[47:0], 24'b0};
        endcase
        wadd = tag_sign_reg ? -$signed({2'b0, wterm}) : $signed({2'b0, wterm});
    end

    assign abs_nu  = nu_reg[97]  ? 97'(-nu_reg)  : 97'(nu_reg);
    assign abs_nv  = nv_reg[97]  ? 97'(-nv_reg)  : 97'(nv_reg);
    assign abs_den = den_reg[97] ? 97'(-den_reg) : 97'(den_reg);

    // final saturation and inside test
    always_comb
    begin
        lim_u  = neg_u_reg ? 34'h080000000 : 34'h07FFFFFFF;
        lim_v  = neg_v_reg ? 34'h080000000 : 34'h07FFFFFFF;
        qf_u   = (sat_u_reg || q_u_reg > lim_u) ? lim_u : q_u_reg;
        qf_v   = (sat_v_reg || q_v_reg > lim_v) ? lim_v : q_v_reg;
        nq_u   = 34'd0 - qf_u;
        nq_v   = 34'd0 - qf_v;
        u_fin  = degen_reg ? 32'sd0 : (neg_u_reg ? nq_u[31:0] : qf_u[31:0]);
        v_fin  = degen_reg ? 32'sd0 : (neg_v_reg ? nq_v[31:0] : qf_v[31:0]);
        uv_sum = 33'(u_fin) + 33'(v_fin);
        one_q  = 33'sd1 <<< FRAC_BITS;
        inside_fin = !degen_reg && !u_fin[31] && !v_fin[31] && uv_sum <= one_q;
    end

    // control
    always_comb
    begin
        state_next = state_reg;
        step_next  = step_reg;
        hi_next    = hi_reg;
        lo_next    = lo_reg;
        q_pop      = 1'b0;
        out_load   = 1'b0;
        if (issue)
        begin
            if (lo_reg == lo_last)
            begin
                lo_next = '0;
                hi_next = hi_reg + 3'd1;
            end
            else
                lo_next = lo_reg + 2'd1;
        end
        unique case (state_reg)
            S_IDLE:
            begin
                if (q_valid)
                begin
                    q_pop = 1'b1;
                    if (q_job.kind == KIND_QUERY)
                    begin
                        state_next = S_READ;
                        step_next  = '0;
                    end
                    else if (q_job.kind == KIND_OOB)
                        state_next = S_DONE;
                end
            end
            S_READ:
            begin
                step_next = step_reg + 6'd1;
                if (step_reg == 6'd4)
                    state_next = S_PREP;
            end
            S_PREP:
            begin
                state_next = S_DIST;
                hi_next    = '0;
                lo_next    = '0;
            end
            S_DIST, S_PROJ, S_DOT, S_WIDE:
            begin
                if (phase_done)
                begin
                    hi_next = '0;
                    lo_next = '0;
                    step_next = '0;
                    case (state_reg)
                        S_DIST:  state_next = S_PROJ;
                        S_PROJ:  state_next = S_DOT;
                        S_DOT:   state_next = S_WIDE;
                        default: state_next = (den_reg == '0) ? S_DONE : S_DIV;
                    endcase
                end
            end
            S_DIV:
            begin
                step_next = step_reg + 6'd1;
                if (step_reg == 6'(DLAST))
                    state_next = S_DONE;
            end
            S_DONE:
            begin
                if (!out_valid_reg || m_axis_tready)
                begin
                    out_load   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
        out_valid_next = out_load || (out_valid_reg && !m_axis_tready);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            step_reg      <= '0;
            hi_reg        <= '0;
            lo_reg        <= '0;
            pv_reg        <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            step_reg      <= step_next;
            hi_reg        <= hi_next;
            lo_reg        <= lo_next;
            pv_reg        <= issue;
            out_valid_reg <= out_valid_next;
        end
    end

    // datapath
    always_ff @(posedge clk)
    begin
        prod_reg     <= ma * mb;
        tag_hi_reg   <= hi_reg;
        tag_lo_reg   <= lo_reg;
        tag_sign_reg <= wsign;

        if (q_pop)
        begin
            idx_reg   <= q_job.idx;
            p_reg[0]  <= q_job.x;
            p_reg[1]  <= q_job.y;
            p_reg[2]  <= q_job.z;
            degen_reg <= q_job.kind == KIND_OOB;
        end

        if (state_reg == S_READ)
        begin
            case (step_reg[2:0])
                3'd1:
                    for (int i = 0; i < 3; i++)
                        a_reg[i] <= rdata_reg[32*i +: 32];
                3'd2:
                    for (int i = 0; i < 3; i++)
                        b_reg[i] <= rdata_reg[32*i +: 32];
                3'd3:
                    for (int i = 0; i < 3; i++)
                        c_reg[i] <= rdata_reg[32*i +: 32];
                3'd4:
                    for (int i = 0; i < 3; i++)
                        n_reg[i] <= rdata_reg[32*i +: 32];
                default: ;
            endcase
        end

        if (state_reg == S_PREP)
        begin
            for (int i = 0; i < 3; i++)
            begin
                pa_reg[i] <= sat32(68'(p_reg[i]) - 68'(a_reg[i]));
                ab_reg[i] <= sat32(68'(b_reg[i]) - 68'(a_reg[i]));
                ac_reg[i] <= sat32(68'(c_reg[i]) - 68'(a_reg[i]));
            end
            acc_reg <= '0;
            den_reg <= '0;
            nu_reg  <= '0;
            nv_reg  <= '0;
        end

        if (pv_reg)
        begin
            case (state_reg)
                S_DIST:
                begin
                    if (tag_lo_reg == 2'd2)
                    begin
                        dist_reg <= sat32(68'(sat48(sum)));
                        acc_reg  <= '0;
                    end
                    else
                        acc_reg <= sum;
                end
                S_PROJ:
                    w_reg[tag_lo_reg] <= sat32(68'(q_proj) - 68'(a_reg[tag_lo_reg]));
                S_DOT:
                begin
                    if (tag_lo_reg == 2'd2)
                    begin
                        d_reg[tag_hi_reg] <= sat48(sum);
                        acc_reg           <= '0;
                    end
                    else
                        acc_reg <= sum;
                end
                S_WIDE:
                begin
                    case (tag_hi_reg[2:1])
                        2'd0:    den_reg <= den_reg + wadd;
                        2'd1:    nu_reg  <= nu_reg + wadd;
                        default: nv_reg  <= nv_reg + wadd;
                    endcase
                end
                default: ;
            endcase
        end

        // divider setup: magnitudes, numerators scaled by the fraction bits
        if (state_reg == S_WIDE && phase_done)
        begin
            rem_u_reg <= DIVW'(abs_nu) << FRAC_BITS;
            rem_v_reg <= DIVW'(abs_nv) << FRAC_BITS;
            dsh_reg   <= DIVW'(abs_den) << DLAST;
            neg_u_reg <= nu_reg[97] != den_reg[97];
            neg_v_reg <= nv_reg[97] != den_reg[97];
            q_u_reg   <= '0;
            q_v_reg   <= '0;
            degen_reg <= den_reg == '0;
        end

        if (state_reg == S_DIV)
        begin
            dsh_reg <= dsh_reg >> 1;
            if (step_reg == '0)
            begin
                // quotient would not fit in 34 bits
                sat_u_reg <= rem_u_reg >= dsh_reg;
                sat_v_reg <= rem_v_reg >= dsh_reg;
            end
            else
            begin
                if (rem_u_reg >= dsh_reg)
                begin
                    rem_u_reg <= rem_u_reg - dsh_reg;
                    q_u_reg   <= {q_u_reg[32:0], 1'b1};
                end
                else
                    q_u_reg <= {q_u_reg[32:0], 1'b0};
                if (rem_v_reg >= dsh_reg)
                begin
                    rem_v_reg <= rem_v_reg - dsh_reg;
                    q_v_reg   <= {q_v_reg[32:0], 1'b1};
                end
                else
                    q_v_reg <= {q_v_reg[32:0], 1'b0};
            end
        end

        if (out_load)
        begin
            out_in_reg <= inside_fin;
            out_dg_reg <= degen_reg;
            out_u_reg  <= u_fin;
            out_v_reg  <= v_fin;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {out_v_reg, out_u_reg};
    assign m_axis_tuser  = {out_dg_reg, out_in_reg};

`ifndef SYNTHESIS
    a_flags: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> !(out_in_reg && out_dg_reg))
        else $error("inside and degenerate both set");
    a_pop_idle: assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |-> state_reg == S_IDLE)
        else $error("queue popped while busy");
    a_div_end: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DIV && step_reg == 6'(DLAST)) |=> state_reg == S_DONE)
        else $error("divider overran its step count");
`endif

endmodule
